// File: rtl/prlm_pkg.sv
// shared types and constants of the particle ring lifetime manager
`timescale 1ns / 1ps
package prlm_pkg;

    // request kinds carried on s_tuser
    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_FRAME = 2'd2;

    // register indexes, byte address is 4 times the index
    localparam logic [1:0] REG_LIFETIME     = 2'd0;
    localparam logic [1:0] REG_SLOTS_IN_USE = 2'd1;
    localparam logic [1:0] REG_FRAME_DELAY  = 2'd2;

    localparam logic [31:0] LIFETIME_RST     = 32'd131072;
    localparam logic [10:0] SLOTS_IN_USE_RST = 11'd1024;
    localparam logic [7:0]  FRAME_DELAY_RST  = 8'd3;

    localparam int IN_W     = 32;
    localparam int USER_W   = 2;
    localparam int RES_W    = 75;
    localparam int OUT_W    = 80;
    localparam int PADDR_W  = 4;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_EXEC,
        CMD_TIME,
        CMD_ACT_RD,
        CMD_RETIRE,
        CMD_WALK_SWITCH,
        CMD_RET_RD,
        CMD_FREE,
        CMD_FIN
    } dp_op_t;

    typedef struct packed {
        logic   capture;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic out_free;
        logic act_stop;
        logic act_old;
        logic ret_stop;
        logic ret_ok;
    } dp_status_t;

    // first member is the highest bits, status ends up at bit 0
    typedef struct packed {
        logic [10:0] draw_wrap_count;
        logic [10:0] draw_count;
        logic [9:0]  draw_start;
        logic [10:0] upload_wrap_count;
        logic [10:0] upload_count;
        logic [9:0]  upload_start;
        logic [9:0]  slot;
        logic        status;
    } result_t;

    typedef struct packed {
        logic [10:0] wrap;
        logic [10:0] cnt;
        logic [9:0]  start;
    } range_t;

endpackage

// File: rtl/prlm_ctrl.sv
// controller state machine sequencing requests and the tick walks
`timescale 1ns / 1ps
module prlm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  prlm_pkg::dp_status_t status,
    output prlm_pkg::dp_cmd_t    cmd
);
    import prlm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ACT_RD,
        ST_ACT_CHK,
        ST_RET_RD,
        ST_RET_CHK,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;
    dp_op_t op;

    always_comb
    begin
        state_next = state_reg;
        op         = CMD_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && ready_reg)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (status.is_tick)
                begin
                    op         = CMD_TIME;
                    state_next = ST_ACT_RD;
                end
                else if (status.out_free)
                begin
                    op         = CMD_EXEC;
                    state_next = ST_IDLE;
                end
            end
            ST_ACT_RD:
            begin
                if (status.act_stop)
                begin
                    op         = CMD_WALK_SWITCH;
                    state_next = ST_RET_RD;
                end
                else
                begin
                    op         = CMD_ACT_RD;
                    state_next = ST_ACT_CHK;
                end
            end
            ST_ACT_CHK:
            begin
                if (status.act_old)
                begin
                    op         = CMD_RETIRE;
                    state_next = ST_ACT_RD;
                end
                else
                begin
                    op         = CMD_WALK_SWITCH;
                    state_next = ST_RET_RD;
                end
            end
            ST_RET_RD:
            begin
                if (status.ret_stop)
                    state_next = ST_FIN;
                else
                begin
                    op         = CMD_RET_RD;
                    state_next = ST_RET_CHK;
                end
            end
            ST_RET_CHK:
            begin
                if (status.ret_ok)
                begin
                    op         = CMD_FREE;
                    state_next = ST_RET_RD;
                end
                else
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    op         = CMD_FIN;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign cmd.capture = s_tvalid && ready_reg;
    assign cmd.op      = op;
    assign s_tready    = ready_reg;

endmodule

// File: rtl/prlm_dpath.sv
// datapath: ring heads, clocks, stamp memory and result register
`timescale 1ns / 1ps
module prlm_dpath #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  prlm_pkg::dp_cmd_t          cmd,
    output prlm_pkg::dp_status_t       status,
    input  logic [prlm_pkg::IN_W-1:0]  elapsed_time,
    input  logic [prlm_pkg::USER_W-1:0] req_type,
    input  logic [31:0]                lifetime,
    input  logic [10:0]                slots_in_use,
    input  logic [7:0]                 frame_delay,
    input  logic                       m_tready,
    output logic                       m_tvalid,
    output prlm_pkg::result_t          result
);
    import prlm_pkg::*;

    localparam int PW = $clog2(MAX_SLOTS);
    localparam int NW = $clog2(MAX_SLOTS + 1);

    logic [PW-1:0] active_reg, new_reg, free_reg, retired_reg;
    logic [31:0]   now_reg, frame_reg;
    logic [NW-1:0] cnt_reg;
    logic          out_valid_reg;
    result_t       out_reg;
    logic [1:0]    req_reg;
    logic [31:0]   dt_reg;
    logic [31:0]   rd_data_reg;
    logic [31:0]   stamp_mem [MAX_SLOTS];

    logic [31:0]   siu32, ring32;
    logic [NW-1:0] ring_n;
    logic [PW-1:0] add_next;
    logic          add_full;
    logic [32:0]   time_sum;
    logic [31:0]   time_sat;
    result_t       exec_res;
    range_t        up_rng, draw_rng;
    logic          mem_we, mem_re;
    logic [PW-1:0] mem_waddr, mem_raddr;
    logic [31:0]   mem_wdata;
    logic [31:0]   head_ext;

    function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [NW-1:0] n);
        logic [NW-1:0] q;
        begin
            q = NW'(p) + NW'(1);
            return (q >= n) ? '0 : q[PW-1:0];
        end
    endfunction

    // range from a up to b, split where it passes the end of the ring
    function automatic range_t split(input logic [PW-1:0] a, input logic [PW-1:0] b,
                                     input logic [NW-1:0] n);
        range_t      r;
        logic [31:0] a32, b32, n32, d32;
        begin
            a32 = 32'(a);
            b32 = 32'(b);
            n32 = 32'(n);
            d32 = '0;
            r   = '0;
            if (a != b)
            begin
                r.start = a32[9:0];
                if (a < b)
                begin
                    d32   = b32 - a32;
                    r.cnt = d32[10:0];
                end
                else
                begin
                    d32    = (n32 > a32) ? (n32 - a32) : 32'd0;
                    r.cnt  = d32[10:0];
                    r.wrap = b32[10:0];
                end
            end
            return r;
        end
    endfunction

    // ring size clamped to 2..MAX_SLOTS
    always_comb
    begin
        siu32 = 32'(slots_in_use);
        if (siu32 < 32'd2)
            ring32 = 32'd2;
        else if (siu32 > 32'(MAX_SLOTS))
            ring32 = 32'(MAX_SLOTS);
        else
            ring32 = siu32;
        ring_n = ring32[NW-1:0];
    end

    always_comb
    begin
        add_next = adv(free_reg, ring_n);
        add_full = (add_next == retired_reg);
        time_sum = {1'b0, now_reg} + {1'b0, dt_reg};
        time_sat = time_sum[32] ? 32'hFFFF_FFFF : time_sum[31:0];
        up_rng   = split(new_reg, free_reg, ring_n);
        draw_rng = split(active_reg, free_reg, ring_n);
        head_ext = 32'(free_reg);
        exec_res = '0;
        case (req_reg)
            REQ_ADD:
            begin
                if (add_full)
                    exec_res.status = 1'b1;
                else
                    exec_res.slot = head_ext[9:0];
            end
            REQ_FRAME:
            begin
                exec_res.upload_start      = up_rng.start;
                exec_res.upload_count      = up_rng.cnt;
                exec_res.upload_wrap_count = up_rng.wrap;
                exec_res.draw_start        = draw_rng.start;
                exec_res.draw_count        = draw_rng.cnt;
                exec_res.draw_wrap_count   = draw_rng.wrap;
            end
            default:
            begin
                exec_res = '0;
            end
        endcase
    end

    always_comb
    begin
        status.is_tick  = (req_reg == REQ_TICK);
        status.out_free = !out_valid_reg || m_tready;
        status.act_stop = (active_reg == new_reg) || (cnt_reg == NW'(MAX_SLOTS));
        status.act_old  = (rd_data_reg <= now_reg) && ((now_reg - rd_data_reg) >= lifetime);
        status.ret_stop = (retired_reg == active_reg) || (cnt_reg == NW'(MAX_SLOTS));
        status.ret_ok   = (rd_data_reg <= frame_reg)
                       && ((frame_reg - rd_data_reg) >= {24'd0, frame_delay});
    end

    always_comb
    begin
        mem_we    = ((cmd.op == CMD_EXEC) && (req_reg == REQ_ADD) && !add_full)
                 || (cmd.op == CMD_RETIRE);
        mem_waddr = (cmd.op == CMD_RETIRE) ? active_reg : free_reg;
        mem_wdata = (cmd.op == CMD_RETIRE) ? frame_reg : now_reg;
        mem_re    = (cmd.op == CMD_ACT_RD) || (cmd.op == CMD_RET_RD);
        mem_raddr = (cmd.op == CMD_RET_RD) ? retired_reg : active_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            stamp_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= stamp_mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req_type;
            dt_reg  <= elapsed_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= '0;
            new_reg       <= '0;
            free_reg      <= '0;
            retired_reg   <= '0;
            now_reg       <= '0;
            frame_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            case (cmd.op)
                CMD_EXEC:
                begin
                    out_valid_reg <= 1'b1;
                    out_reg       <= exec_res;
                    if ((req_reg == REQ_ADD) && !add_full)
                        free_reg <= add_next;
                    if (req_reg == REQ_FRAME)
                    begin
                        new_reg <= free_reg;
                        if (frame_reg != 32'hFFFF_FFFF)
                            frame_reg <= frame_reg + 32'd1;
                    end
                end
                CMD_TIME:
                begin
                    now_reg <= time_sat;
                    cnt_reg <= '0;
                end
                CMD_RETIRE:
                begin
                    active_reg <= adv(active_reg, ring_n);
                    cnt_reg    <= cnt_reg + NW'(1);
                end
                CMD_WALK_SWITCH:
                begin
                    cnt_reg <= '0;
                end
                CMD_FREE:
                begin
                    retired_reg <= adv(retired_reg, ring_n);
                    cnt_reg     <= cnt_reg + NW'(1);
                end
                CMD_FIN:
                begin
                    out_valid_reg <= 1'b1;
                    out_reg       <= '0;
                    // no live particles: restart the clock
                    if (active_reg == free_reg)
                        now_reg <= '0;
                    if (retired_reg == active_reg)
                        frame_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign result   = out_reg;

endmodule

// File: rtl/particle_ring_lifetime_manager.sv
// top level: register port, controller and datapath of the particle ring
// add, frame and unused requests are answered from the exec state once the output is free
// one request is taken at a time; s_tready stays low until the controller is idle again
// a tick walks retire, then free; each step reads through the single stamp memory read port
// reset clears the four heads, time and frame count and sets the registers to reset values;
// the stamp memory is not cleared
`timescale 1ns / 1ps
module particle_ring_lifetime_manager #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [prlm_pkg::IN_W-1:0]     s_tdata,   // elapsed_time
    input  logic [prlm_pkg::USER_W-1:0]   s_tuser,   // req_type
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status, slot, upload_start, upload_count, upload_wrap_count,
    // draw_start, draw_count, draw_wrap_count, zero fill
    output logic [prlm_pkg::OUT_W-1:0]    m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [prlm_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import prlm_pkg::*;

    logic [31:0] lifetime_reg;
    logic [10:0] slots_in_use_reg;
    logic [7:0]  frame_delay_reg;
    dp_cmd_t     cmd;
    dp_status_t  status;
    result_t     result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lifetime_reg     <= LIFETIME_RST;
            slots_in_use_reg <= SLOTS_IN_USE_RST;
            frame_delay_reg  <= FRAME_DELAY_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[3:2])
                REG_LIFETIME:     lifetime_reg     <= pwdata;
                REG_SLOTS_IN_USE: slots_in_use_reg <= pwdata[10:0];
                REG_FRAME_DELAY:  frame_delay_reg  <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_LIFETIME:     prdata = lifetime_reg;
            REG_SLOTS_IN_USE: prdata = {21'd0, slots_in_use_reg};
            REG_FRAME_DELAY:  prdata = {24'd0, frame_delay_reg};
            default:          prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    prlm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    prlm_dpath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .elapsed_time (s_tdata),
        .req_type     (s_tuser),
        .lifetime     (lifetime_reg),
        .slots_in_use (slots_in_use_reg),
        .frame_delay  (frame_delay_reg),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .result       (result)
    );

    assign m_tdata = {(OUT_W - RES_W)'(0), result};

endmodule

// File: rtl/prlm_checker.sv
// port-level checks of the particle ring, bound to the top level
`timescale 1ns / 1ps
module prlm_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [prlm_pkg::OUT_W-1:0] m_tdata,
    input logic                       pready
);
    import prlm_pkg::*;

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request at a time: busy right after a transfer
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a request is in flight");

    // a result is only loaded while a request is in flight
    a_result_from_request: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without a request");

    // a full ring answer carries nothing else
    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> (m_tdata[OUT_W-1:1] == '0))
        else $error("full ring result has nonzero fields");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("register port stalled");

endmodule

bind particle_ring_lifetime_manager prlm_checker u_prlm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);

// File: verif/ring_result_checker.sv
// result checker: predicts the ring manager's responses and compares each result transfer
`timescale 1ns / 1ps
module ring_result_checker #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [prlm_pkg::IN_W-1:0]      s_tdata,
    input  logic [prlm_pkg::USER_W-1:0]    s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [prlm_pkg::OUT_W-1:0]     m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [prlm_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    input  logic                           pready,
    output logic [31:0]                    mismatches,
    output logic [31:0]                    pending
);
    import prlm_pkg::*;

    // predicted block state
    logic [31:0] stamp_mem [MAX_SLOTS];
    logic [9:0]  act_hd;
    logic [9:0]  new_hd;
    logic [9:0]  free_hd;
    logic [9:0]  ret_hd;
    logic [31:0] clock_now;
    logic [31:0] frames;
    logic [31:0] life_cfg;
    logic [10:0] slots_cfg;
    logic [7:0]  delay_cfg;

    result_t     awaited [$];
    logic [31:0] miss_total;

    // result fields from bit 0 up, zero fill last
    int    field_bits [9] = '{1, 10, 10, 11, 11, 10, 11, 11, 5};
    string field_name [9] = '{"status", "slot", "upload_start", "upload_count",
                              "upload_wrap_count", "draw_start", "draw_count",
                              "draw_wrap_count", "zero_fill"};

    function automatic logic [10:0] ring_len();
        if (slots_cfg < 11'd2)
            return 11'd2;
        if (slots_cfg > MAX_SLOTS)
            return 11'(MAX_SLOTS);
        return slots_cfg;
    endfunction

    function automatic logic [9:0] step_head(input logic [9:0] p, input logic [10:0] n);
        logic [10:0] q;
        q = {1'b0, p} + 11'd1;
        return (q >= n) ? 10'd0 : q[9:0];
    endfunction

    // split the range a..b at the end of the ring
    function automatic range_t span(input logic [9:0] a, input logic [9:0] b,
                                    input logic [10:0] n);
        range_t r;
        r = '0;
        if (a != b)
        begin
            r.start = a;
            if (a < b)
                r.cnt = {1'b0, b} - {1'b0, a};
            else
            begin
                r.cnt  = (n > {1'b0, a}) ? n - {1'b0, a} : 11'd0;
                r.wrap = {1'b0, b};
            end
        end
        return r;
    endfunction

    function automatic result_t serve_request(input logic [1:0] kind, input logic [31:0] dt);
        result_t     res;
        logic [10:0] n;
        logic [9:0]  nxt;
        logic [32:0] sum;
        logic [31:0] s;
        range_t      up;
        range_t      dr;
        int          steps;
        bit          halt;
        res = '0;
        n = ring_len();
        case (kind)
            REQ_ADD:
            begin
                nxt = step_head(free_hd, n);
                if (nxt == ret_hd)
                    res.status = 1'b1;
                else
                begin
                    stamp_mem[free_hd] = clock_now;
                    res.slot = free_hd;
                    free_hd = nxt;
                end
            end
            REQ_TICK:
            begin
                sum = {1'b0, clock_now} + {1'b0, dt};
                clock_now = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                // retire walk, restamp with the frame count
                steps = 0;
                halt = 1'b0;
                while (!halt && steps < MAX_SLOTS && act_hd != new_hd)
                begin
                    s = stamp_mem[act_hd];
                    if (s > clock_now || clock_now - s < life_cfg)
                        halt = 1'b1;
                    else
                    begin
                        stamp_mem[act_hd] = frames;
                        act_hd = step_head(act_hd, n);
                        steps++;
                    end
                end
                // free walk
                steps = 0;
                halt = 1'b0;
                while (!halt && steps < MAX_SLOTS && ret_hd != act_hd)
                begin
                    s = stamp_mem[ret_hd];
                    if (s > frames || frames - s < {24'd0, delay_cfg})
                        halt = 1'b1;
                    else
                    begin
                        ret_hd = step_head(ret_hd, n);
                        steps++;
                    end
                end
                if (act_hd == free_hd)
                    clock_now = '0;
                if (ret_hd == act_hd)
                    frames = '0;
            end
            REQ_FRAME:
            begin
                up = span(new_hd, free_hd, n);
                new_hd = free_hd;
                dr = span(act_hd, free_hd, n);
                res.upload_start      = up.start;
                res.upload_count      = up.cnt;
                res.upload_wrap_count = up.wrap;
                res.draw_start        = dr.start;
                res.draw_count        = dr.cnt;
                res.draw_wrap_count   = dr.wrap;
                if (frames != 32'hFFFF_FFFF)
                    frames++;
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic compare_result(input result_t want, input logic [OUT_W-1:0] got_bits);
        logic [OUT_W-1:0] want_bits;
        logic [15:0]      wv;
        logic [15:0]      gv;
        int               off;
        want_bits = '0;
        want_bits[RES_W-1:0] = want;
        off = 0;
        for (int f = 0; f < 9; f++)
        begin
            wv = '0;
            gv = '0;
            for (int b = 0; b < field_bits[f]; b++)
            begin
                wv[b] = want_bits[off + b];
                gv[b] = got_bits[off + b];
            end
            if (gv !== wv)
            begin
                $display("%0t: %s expected %0d actual %0d", $time, field_name[f], wv, gv);
                miss_total++;
            end
            off += field_bits[f];
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_hd     = '0;
            new_hd     = '0;
            free_hd    = '0;
            ret_hd     = '0;
            clock_now  = '0;
            frames     = '0;
            life_cfg   = LIFETIME_RST;
            slots_cfg  = SLOTS_IN_USE_RST;
            delay_cfg  = FRAME_DELAY_RST;
            miss_total = '0;
            awaited.delete();
            pending    <= '0;
            mismatches <= '0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[PADDR_W-1:2])
                    REG_LIFETIME:     life_cfg  = pwdata;
                    REG_SLOTS_IN_USE: slots_cfg = pwdata[10:0];
                    REG_FRAME_DELAY:  delay_cfg = pwdata[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                awaited.push_back(serve_request(s_tuser, s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (awaited.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected, actual %h",
                             $time, m_tdata);
                    miss_total++;
                end
                else
                    compare_result(awaited.pop_front(), m_tdata);
            end
            pending    <= awaited.size();
            mismatches <= miss_total;
        end
    end

endmodule

// File: verif/testbench.sv
// top of the ring manager testbench: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps
module testbench;
    import prlm_pkg::*;

    localparam logic [1:0] REQ_IDLE    = 2'd3;
    localparam int         RUN_LIMIT   = 1_000_000;
    localparam int         HOLD_CYCLES = 400;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata = '0;     // elapsed_time
    logic [USER_W-1:0]    s_tuser = '0;     // req_type
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // status, slot, upload_start, upload_count, upload_wrap_count,
    // draw_start, draw_count, draw_wrap_count, zero fill
    logic [OUT_W-1:0]     m_tdata;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    logic [31:0]          mismatches;
    logic [31:0]          pending;

    int unsigned          send_idle_pct = 22;
    int unsigned          recv_idle_pct = 85;
    int unsigned          hold_asks = 0;
    int unsigned          hold_served = 0;
    int unsigned          hold_left = 0;
    int unsigned          cycle_count = 0;

    particle_ring_lifetime_manager i_dut (.*);

    ring_result_checker i_ring_check (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    // receiver side, with an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (hold_asks != hold_served)
        begin
            hold_served++;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_request(input logic [1:0] kind, input logic [31:0] dt);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= dt;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // stop sending and let every outstanding result come back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // empty all four regions so the ring size can change safely
    task automatic flush_ring();
        settle();
        write_reg(REG_LIFETIME, 32'd0);
        write_reg(REG_FRAME_DELAY, 32'd0);
        push_request(REQ_FRAME, $urandom());
        push_request(REQ_TICK, 32'd0);
        settle();
    endtask

    task automatic random_request();
        int unsigned roll;
        logic [1:0]  kind;
        logic [31:0] dt;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            kind = REQ_ADD;
        else if (roll < 65)
            kind = REQ_FRAME;
        else if (roll < 95)
            kind = REQ_TICK;
        else
            kind = REQ_IDLE;
        dt = $urandom();
        if (kind == REQ_TICK)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
                dt = $urandom_range(0, 32'h0003_0000);
            else if (roll < 80)
                dt = $urandom_range(0, 32'h0000_FFFF);
            else if (roll < 92)
                dt = 32'd0;
        end
        push_request(kind, dt);
    endtask

    task automatic run_phase(input int p);
        logic [10:0] size;
        logic [31:0] life;
        logic [7:0]  delay;
        int          count;
        case (p)
            0:
            begin
                size = 11'd16;   life = 32'h0002_0000; delay = 8'd3;   count = 90;
            end
            1:
            begin
                size = 11'd1;    life = 32'd0;         delay = 8'd0;   count = 60;
            end
            2:
            begin
                size = 11'd2047; life = 32'hFFFF_FFFF; delay = 8'd255; count = 70;
            end
            3:
            begin
                size  = 11'd5;
                life  = $urandom_range(1, 32'h0004_0000);
                delay = 8'($urandom_range(0, 6));
                count = 90;
            end
            4:
            begin
                size = 11'd1024; life = 32'h0001_8000; delay = 8'd1;   count = 100;
            end
            5:
            begin
                size = 11'd2;    life = 32'h0000_8000; delay = 8'd2;   count = 50;
            end
            default:
            begin
                size  = 11'd64;
                life  = $urandom_range(0, 32'h0003_0000);
                delay = 8'($urandom_range(0, 4));
                count = 60;
            end
        endcase
        if (p < 2)
        begin
            send_idle_pct = 22;
            recv_idle_pct = 85;
        end
        else if (p < 4)
        begin
            send_idle_pct = 85;
            recv_idle_pct = 22;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        flush_ring();
        write_reg(REG_SLOTS_IN_USE, {21'd0, size});
        write_reg(REG_LIFETIME, life);
        write_reg(REG_FRAME_DELAY, {24'd0, delay});
        // back-pressure long enough to fill the block and stall its input
        if (p == 4)
            hold_asks++;
        repeat (count) random_request();
        settle();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full-size ring at reset settings: empty frame, idle request, time saturation
        push_request(REQ_FRAME, 32'hFFFF_FFFF);
        push_request(REQ_TICK, 32'd0);
        push_request(REQ_IDLE, 32'hFFFF_FFFF);
        push_request(REQ_ADD, 32'd0);
        push_request(REQ_ADD, 32'hFFFF_FFFF);
        push_request(REQ_FRAME, 32'd0);
        push_request(REQ_ADD, $urandom());
        push_request(REQ_TICK, 32'hFFFF_FFFF);
        push_request(REQ_TICK, 32'h0001_0000);
        push_request(REQ_FRAME, 32'd0);
        push_request(REQ_TICK, 32'd0);

        // four-slot ring: full on add, ranges split at the wrap
        flush_ring();
        write_reg(REG_SLOTS_IN_USE, 32'd4);
        repeat (4) push_request(REQ_ADD, $urandom());
        push_request(REQ_FRAME, 32'd0);
        push_request(REQ_TICK, 32'd0);
        repeat (3) push_request(REQ_ADD, $urandom());
        push_request(REQ_FRAME, 32'd0);
        push_request(REQ_TICK, 32'h0000_0001);
        push_request(REQ_FRAME, 32'd0);
        settle();

        for (int p = 0; p < 7; p++)
            run_phase(p);

        settle();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
